[design/qphs_pkg.sv]
package qphs_pkg;

  localparam int TABLE_DEPTH_DEF = 128;
  localparam int KEY_W           = 31;
  localparam int SIZE_W          = 8;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd128;

  // Probed slots always sit below the 8-bit table size.
  localparam int MAX_SLOTS = (1 << SIZE_W) - 1;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  localparam logic [1:0] STATUS_INSERTED  = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_FOUND     = 2'd2;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_LOOK,
    ST_CMP
  } state_e;

endpackage

[design/qphs_ram.sv]
module qphs_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 128,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[design/qphs_modadd.sv]
// Shared modular adder: (a + b + cin) mod m, valid for a, b below m.
module qphs_modadd (
  input  logic [qphs_pkg::SIZE_W-1:0] a_i,
  input  logic [qphs_pkg::SIZE_W-1:0] b_i,
  input  logic                        cin_i,
  input  logic [qphs_pkg::SIZE_W-1:0] mod_i,
  output logic [qphs_pkg::SIZE_W-1:0] sum_o
);

  logic [qphs_pkg::SIZE_W:0] raw;
  logic [qphs_pkg::SIZE_W:0] red;

  always_comb begin
    raw = {1'b0, a_i} + {1'b0, b_i} + {{qphs_pkg::SIZE_W{1'b0}}, cin_i};
    red = raw - {1'b0, mod_i};
    if (raw >= {1'b0, mod_i}) begin
      sum_o = red[qphs_pkg::SIZE_W-1:0];
    end else begin
      sum_o = raw[qphs_pkg::SIZE_W-1:0];
    end
  end

endmodule

[design/quadratic_probe_hash_set_top.sv]
// Open-addressed key set with quadratic probing over table_size slots
// (0 reads as 1, values above the depth saturate). A request is taken when
// start_i is high and busy_o is low; its status appears on status_o as done_o
// goes high for one cycle, and cannot be held off. Each request first reduces
// the key modulo the table size, one key bit per cycle through the shared
// modular adder, then probes: each probe is a registered read of the key
// memory, then a compare, with 1 to table_size probes per request. The next
// request is accepted in the cycle done_o shows.
// Slot valid flags clear at reset; there is no clearing pass.
module quadratic_probe_hash_set_top #(
  parameter int TABLE_DEPTH = qphs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  output logic                             busy_o,
  input  logic                             func_i,
  input  logic [qphs_pkg::KEY_W-1:0]       key_i,
  output logic                             done_o,
  output logic [1:0]                       status_o,
  input  logic                             cfg_we_i,
  input  logic [qphs_pkg::SIZE_W-1:0]      cfg_wdata_i
);

  localparam int SLOTS = (TABLE_DEPTH < qphs_pkg::MAX_SLOTS) ? TABLE_DEPTH
                                                             : qphs_pkg::MAX_SLOTS;
  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BIT_W = $clog2(qphs_pkg::KEY_W);
  localparam logic [qphs_pkg::SIZE_W-1:0] SLOTS_M = qphs_pkg::SIZE_W'(SLOTS);

  qphs_pkg::state_e state_q, state_d;

  logic [qphs_pkg::SIZE_W-1:0] size_q;
  logic [qphs_pkg::SIZE_W-1:0] m_act;
  logic [qphs_pkg::KEY_W-1:0]  key_q, key_d;
  logic                        func_q, func_d;
  logic [BIT_W-1:0]            bit_q, bit_d;
  logic [qphs_pkg::SIZE_W-1:0] s_q, s_d;
  logic [qphs_pkg::SIZE_W-1:0] d_q, d_d;
  logic [qphs_pkg::SIZE_W-1:0] cnt_q, cnt_d;
  logic [SLOTS-1:0]            valid_q;
  logic                        set_valid;
  logic                        done_q, done_d;
  logic [1:0]                  status_q, status_d;

  logic [qphs_pkg::SIZE_W-1:0] ua, ub, usum;
  logic                        ucin;
  logic [qphs_pkg::SIZE_W:0]   d_inc;
  logic [qphs_pkg::KEY_W-1:0]  rdata;
  logic                        ram_we;
  logic                        slot_valid;

  always_comb begin
    if (size_q == '0) begin
      m_act = qphs_pkg::SIZE_W'(1);
    end else if (size_q > SLOTS_M) begin
      m_act = SLOTS_M;
    end else begin
      m_act = size_q;
    end
  end

  // Remainder step doubles s and shifts in a key bit; probe step adds d.
  always_comb begin
    if (state_q == qphs_pkg::ST_MOD) begin
      ua   = s_q;
      ub   = s_q;
      ucin = key_q[bit_q];
    end else begin
      ua   = s_q;
      ub   = d_q;
      ucin = 1'b0;
    end
  end

  qphs_modadd u_modadd (
    .a_i   (ua),
    .b_i   (ub),
    .cin_i (ucin),
    .mod_i (m_act),
    .sum_o (usum)
  );

  qphs_ram #(
    .WIDTH (qphs_pkg::KEY_W),
    .DEPTH (SLOTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (s_q[SW-1:0]),
    .wdata_i (key_q),
    .rdata_o (rdata)
  );

  assign slot_valid = valid_q[s_q[SW-1:0]];
  assign d_inc      = {1'b0, d_q} + (qphs_pkg::SIZE_W+1)'(2);

  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    func_d    = func_q;
    bit_d     = bit_q;
    s_d       = s_q;
    d_d       = d_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    status_d  = status_q;
    ram_we    = 1'b0;
    set_valid = 1'b0;
    unique case (state_q)
      qphs_pkg::ST_IDLE: begin
        if (start_i) begin
          key_d   = key_i;
          func_d  = func_i;
          bit_d   = BIT_W'(qphs_pkg::KEY_W - 1);
          s_d     = '0;
          state_d = qphs_pkg::ST_MOD;
        end
      end
      qphs_pkg::ST_MOD: begin
        s_d = usum;
        if (bit_q == '0) begin
          d_d     = qphs_pkg::SIZE_W'(1);
          cnt_d   = '0;
          state_d = qphs_pkg::ST_LOOK;
        end else begin
          bit_d = bit_q - BIT_W'(1);
        end
      end
      qphs_pkg::ST_LOOK: begin
        state_d = qphs_pkg::ST_CMP;
      end
      qphs_pkg::ST_CMP: begin
        if (!slot_valid) begin
          done_d  = 1'b1;
          state_d = qphs_pkg::ST_IDLE;
          if (func_q == qphs_pkg::FUNC_INSERT) begin
            ram_we    = 1'b1;
            set_valid = 1'b1;
            status_d  = qphs_pkg::STATUS_INSERTED;
          end else begin
            status_d  = qphs_pkg::STATUS_NOT_FOUND;
          end
        end else if (func_q == qphs_pkg::FUNC_SEARCH && rdata == key_q) begin
          done_d   = 1'b1;
          status_d = qphs_pkg::STATUS_FOUND;
          state_d  = qphs_pkg::ST_IDLE;
        end else if (cnt_q == m_act - qphs_pkg::SIZE_W'(1)) begin
          done_d   = 1'b1;
          status_d = (func_q == qphs_pkg::FUNC_INSERT) ? qphs_pkg::STATUS_FULL
                                                       : qphs_pkg::STATUS_NOT_FOUND;
          state_d  = qphs_pkg::ST_IDLE;
        end else begin
          // (i+1)^2 = i^2 + (2i+1); d tracks 2i+1 mod m
          s_d   = usum;
          d_d   = (d_inc >= {1'b0, m_act}) ? qphs_pkg::SIZE_W'(d_inc - {1'b0, m_act})
                                           : d_inc[qphs_pkg::SIZE_W-1:0];
          cnt_d = cnt_q + qphs_pkg::SIZE_W'(1);
          state_d = qphs_pkg::ST_LOOK;
        end
      end
      default: state_d = qphs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qphs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= qphs_pkg::SIZE_RESET;
      valid_q <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
      if (set_valid) begin
        valid_q[s_q[SW-1:0]] <= 1'b1;
      end
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    func_q   <= func_d;
    bit_q    <= bit_d;
    s_q      <= s_d;
    d_q      <= d_d;
    cnt_q    <= cnt_d;
    status_q <= status_d;
  end

  assign busy_o   = (state_q != qphs_pkg::ST_IDLE);
  assign done_o   = done_q;
  assign status_o = status_q;

`ifndef SYNTHESIS
  a_done_after_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(state_q == qphs_pkg::ST_CMP))
    else $error("result strobe without a compare step");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not raise busy");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == qphs_pkg::ST_LOOK) |-> (s_q < m_act && cnt_q < m_act))
    else $error("probe slot or count out of range");
`endif

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import qphs_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic               func_i;
  logic [KEY_W-1:0]   key_i;
  logic               done_o;
  logic [1:0]         status_o;
  logic               cfg_we_i;
  logic [SIZE_W-1:0]  cfg_wdata_i;

  quadratic_probe_hash_set_top #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .func_i      (func_i),
    .key_i       (key_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // shadow copy of the set
  bit                shadow_valid [DEPTH];
  logic [KEY_W-1:0]  shadow_key   [DEPTH];
  logic [SIZE_W-1:0] shadow_size;

  logic [1:0]        status_due [$];
  logic [KEY_W-1:0]  stored_keys [$];
  logic [1:0]        want_status;
  int                errors;
  bit                idle_on;

  function automatic logic [1:0] hash_set_status(logic f, logic [KEY_W-1:0] k);
    int unsigned     m;
    int unsigned     slot;
    longint unsigned sum;
    m = shadow_size;
    if (m == 0) m = 1;
    if (m > DEPTH) m = DEPTH;
    for (int unsigned i = 0; i < m; i++) begin
      sum = 64'(k) + 64'(i) * 64'(i);
      slot = int'(sum % 64'(m));
      if (!shadow_valid[slot]) begin
        if (f == FUNC_INSERT) begin
          shadow_valid[slot] = 1'b1;
          shadow_key[slot] = k;
          return STATUS_INSERTED;
        end
        return STATUS_NOT_FOUND;
      end
      if (f == FUNC_SEARCH && shadow_key[slot] == k) return STATUS_FOUND;
    end
    return (f == FUNC_INSERT) ? STATUS_FULL : STATUS_NOT_FOUND;
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 3))
      0: k = KEY_W'($urandom_range(0, 300));
      1: k = {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 300));
      default: k = KEY_W'($urandom());
    endcase
    return k;
  endfunction

  // start_i is left high after acceptance unless an idle burst lowers it
  task automatic send_item(logic f, logic [KEY_W-1:0] k);
    logic [1:0] st;
    start_i <= 1'b1;
    func_i  <= f;
    key_i   <= k;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    st = hash_set_status(f, k);
    status_due.push_back(st);
    if (f == FUNC_INSERT && st == STATUS_INSERTED) stored_keys.push_back(k);
    if (idle_on) begin
      case ($urandom_range(0, 3))
        0: begin
          start_i <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
        1: begin
          // gap while the block sits idle
          start_i <= 1'b0;
          while (status_due.size() != 0) @(posedge clk_i);
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
        default: ;
      endcase
    end
  endtask

  task automatic finish_requests();
    start_i <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_table_size(logic [SIZE_W-1:0] v);
    finish_requests();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_size = v;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (status_due.size() == 0) begin
        $error("status: expected none, actual %0d", status_o);
        errors++;
      end else begin
        want_status = status_due.pop_front();
        if (status_o !== want_status) begin
          $error("status: expected %0d, actual %0d", want_status, status_o);
          errors++;
        end
      end
    end
  end

  task automatic test_empty_table();
    send_item(FUNC_SEARCH, '0);
    send_item(FUNC_SEARCH, {KEY_W{1'b1}});
    send_item(FUNC_SEARCH, rand_key());
  endtask

  task automatic test_key_extremes();
    send_item(FUNC_INSERT, '0);
    send_item(FUNC_INSERT, {KEY_W{1'b1}});
    send_item(FUNC_INSERT, KEY_W'(127));     // collides with the max key
    send_item(FUNC_INSERT, '0);              // duplicate lands in another slot
    send_item(FUNC_SEARCH, '0);
    send_item(FUNC_SEARCH, {KEY_W{1'b1}});
    send_item(FUNC_SEARCH, KEY_W'(127));
    send_item(FUNC_SEARCH, KEY_W'(255));     // walks the chain to an empty slot
    send_item(FUNC_SEARCH, KEY_W'(31'h4000_0000));
  endtask

  task automatic test_size_floor();
    set_table_size('0);                      // reads as one slot
    send_item(FUNC_INSERT, KEY_W'(5));
    send_item(FUNC_SEARCH, '0);
    send_item(FUNC_SEARCH, KEY_W'(5));       // every probe occupied, no match
    set_table_size(SIZE_W'(1));
    send_item(FUNC_INSERT, KEY_W'(1));
    send_item(FUNC_SEARCH, '0);
  endtask

  task automatic test_size_ceiling();
    set_table_size({SIZE_W{1'b1}});          // saturates to the depth
    send_item(FUNC_SEARCH, KEY_W'(127));
    send_item(FUNC_SEARCH, {KEY_W{1'b1}});
    send_item(FUNC_INSERT, KEY_W'(31'h5555_5555));
    send_item(FUNC_SEARCH, KEY_W'(31'h2AAA_AAAA));
  endtask

  task automatic test_shrunk_table();
    set_table_size(SIZE_W'(2));
    send_item(FUNC_SEARCH, KEY_W'(127));
    send_item(FUNC_INSERT, KEY_W'(7));
    send_item(FUNC_SEARCH, '0);
    set_table_size(SIZE_RESET);              // old contents visible again
    send_item(FUNC_SEARCH, KEY_W'(31'h5555_5555));
  endtask

  task automatic run_mix(int count);
    logic             f;
    logic [KEY_W-1:0] k;
    for (int n = 0; n < count; n++) begin
      f = ($urandom_range(0, 9) < 4) ? FUNC_INSERT : FUNC_SEARCH;
      if (stored_keys.size() != 0 &&
          $urandom_range(0, 9) < ((f == FUNC_INSERT) ? 2 : 6))
        k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      else
        k = rand_key();
      send_item(f, k);
    end
  endtask

  task automatic test_random_sizes();
    logic [SIZE_W-1:0] sz;
    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(0, 6))
        0: sz = '0;
        1: sz = {SIZE_W{1'b1}};
        2: sz = SIZE_RESET;
        3: sz = SIZE_W'($urandom_range(1, 16));
        default: sz = SIZE_W'($urandom_range(1, 127));
      endcase
      set_table_size(sz);
      run_mix(130);
    end
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    set_table_size(SIZE_W'($urandom_range(1, 128)));
    run_mix(150);
  endtask

  initial begin
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    func_i      = 1'b0;
    key_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    errors      = 0;
    idle_on     = 1'b1;
    shadow_size = SIZE_RESET;
    foreach (shadow_valid[i]) shadow_valid[i] = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_table();
    test_key_extremes();
    test_size_floor();
    test_size_ceiling();
    test_shrunk_table();
    test_random_sizes();
    test_steady_stream();

    finish_requests();
    // longest request: key reduction plus a read and a compare per probe
    repeat (31 + 2 * DEPTH + 20) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS quadratic_probe_hash_set_top");
    end else begin
      $display("FAIL quadratic_probe_hash_set_top");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("FAIL quadratic_probe_hash_set_top");
    $finish;
  end

endmodule
